// File: rtl/core/masked_sync_word_correlator_defines.svh
// assertion macros for the masked sync word correlator
`ifndef MASKED_SYNC_WORD_CORRELATOR_DEFINES_SVH
`define MASKED_SYNC_WORD_CORRELATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MSWC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mswc check failed");

// next-cycle implication, disabled during reset
`define MSWC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mswc check failed");

`endif

// File: rtl/core/mswc_pkg.sv
// shared types, constants and helpers for the masked sync word correlator
`timescale 1ns / 1ps
package mswc_pkg;

  localparam int NUM_LANES = 8;
  localparam int MAX_PATTERN_BYTES = 8;
  localparam logic [21:0] COUNT_MAX = 22'h3FFFFF;
  localparam logic [23:0] OFFSET_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CFG_PATTERN = 2'd0,
    CFG_MASK    = 2'd1,
    CFG_BYTES   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [23:0] bit_offset;
    logic [6:0]  error_count;
    logic        last_of_byte;
  } out_item_t;

  // per lane: eight byte-wise mismatch counts
  typedef logic [7:0][3:0] lane_parts_t;
  typedef lane_parts_t [NUM_LANES-1:0] all_parts_t;
  typedef logic [NUM_LANES-1:0][6:0] lane_sums_t;

  typedef struct packed {
    logic [24:0] base;
    logic        stuck;
    logic        single;
  } item_meta_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/mswc_lane.sv
// one correlator lane: window at a fixed bit lag, masked compare, byte-wise counts
`timescale 1ns / 1ps
module mswc_lane (
  input  logic [71:0]                hist72,
  input  logic [2:0]                 lane_idx,
  input  logic [5:0]                 shamt,
  input  logic [63:0]                pattern,
  input  logic [63:0]                eff_mask,
  output mswc_pkg::lane_parts_t      parts
);

  logic [71:0] shifted;
  logic [63:0] raw;
  logic [63:0] win;
  logic [63:0] diff;

  assign shifted = hist72 >> lane_idx;
  assign raw     = shifted[63:0];
  assign win     = raw << shamt;
  assign diff    = (win ^ pattern) & eff_mask;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      parts[b] = mswc_pkg::popcount8(diff[8*b +: 8]);
    end
  end

endmodule

// File: rtl/core/mswc_merge.sv
// merge stage: sums lane counts, holds one item's results and sends them out in order
`timescale 1ns / 1ps
module mswc_merge (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    s1_valid,
  output logic                    s1_ready,
  input  mswc_pkg::all_parts_t    s1_parts,
  input  mswc_pkg::item_meta_t    s1_meta,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mswc_pkg::out_item_t     out_item
);

  logic                    s2_valid_r, s2_valid_nxt;
  mswc_pkg::lane_sums_t    s2_sums_r, s2_sums_nxt;
  mswc_pkg::item_meta_t    s2_meta_r;
  logic                    bank_valid_r, bank_valid_nxt;
  mswc_pkg::lane_sums_t    bank_sums_r;
  mswc_pkg::item_meta_t    bank_meta_r;
  logic [2:0]              idx_r, idx_nxt;
  logic                    bank_done;
  logic                    bank_free;
  logic                    s2_ready;
  logic [24:0]             off_diff;

  always_comb begin
    for (int l = 0; l < mswc_pkg::NUM_LANES; l++) begin
      s2_sums_nxt[l] = 7'd0;
      for (int b = 0; b < 8; b++) begin
        s2_sums_nxt[l] = s2_sums_nxt[l] + {3'b000, s1_parts[l][b]};
      end
    end
  end

  assign bank_done = bank_valid_r && out_ready && (idx_r == 3'd0);
  assign bank_free = !bank_valid_r || bank_done;
  assign s2_ready  = !s2_valid_r || bank_free;
  assign s1_ready  = s2_ready;

  always_comb begin
    s2_valid_nxt   = s2_valid_r;
    bank_valid_nxt = bank_valid_r;
    idx_nxt        = idx_r;
    if (s2_ready) begin
      s2_valid_nxt = s1_valid;
    end
    if (bank_free) begin
      bank_valid_nxt = s2_valid_r;
      idx_nxt        = s2_meta_r.single ? 3'd0 : 3'd7;
    end else if (bank_valid_r && out_ready) begin
      idx_nxt = idx_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r   <= 1'b0;
      bank_valid_r <= 1'b0;
      idx_r        <= 3'd0;
    end else begin
      s2_valid_r   <= s2_valid_nxt;
      bank_valid_r <= bank_valid_nxt;
      idx_r        <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_sums_r <= s2_sums_nxt;
      s2_meta_r <= s1_meta;
    end
    if (bank_free && s2_valid_r) begin
      bank_sums_r <= s2_sums_r;
      bank_meta_r <= s2_meta_r;
    end
  end

  assign off_diff = bank_meta_r.base - {22'd0, idx_r};

  always_comb begin
    out_item.error_count  = bank_sums_r[idx_r];
    out_item.last_of_byte = (idx_r == 3'd0);
    if (bank_meta_r.stuck || off_diff[24]) begin
      out_item.bit_offset = mswc_pkg::OFFSET_MAX;
    end else begin
      out_item.bit_offset = off_diff[23:0];
    end
  end

  assign out_valid = bank_valid_r;

endmodule

// File: rtl/core/masked_sync_word_correlator.sv
// Masked sync word correlator, top level. Each accepted item carries one stream byte (MSB
// first). Once the pattern window of 8 * pattern_bytes bits is filled, the byte that completes
// it gives one result at offset 0, and every later byte gives eight results, oldest offset
// first, the last flagged with last_of_byte; earlier bytes give none. Eight lanes compare the
// eight candidate windows of a byte in the cycle it is accepted, a sum stage adds the lane
// counts, and the output bank sends one result per cycle while out_ready is high. A byte's
// results pass through the lane register, the sum register and the output bank, whose
// one-result-per-cycle port sets the sustained byte rate. Two further result-giving bytes are
// taken while a byte's results are sent; after that the input stalls until the bank frees up.
// Configuration writes are always ready and must only happen while the block is idle.
`timescale 1ns / 1ps
`include "masked_sync_word_correlator_defines.svh"
module masked_sync_word_correlator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mswc_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mswc_pkg::out_item_t   out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data
);

  logic [63:0]            pattern_r;
  logic [63:0]            pattern_mask_r;
  logic [3:0]             pattern_bytes_r;
  logic [63:0]            hist_r, hist_nxt;
  logic [21:0]            cnt_r, cnt_nxt;
  logic                   s1_valid_r, s1_valid_nxt;
  mswc_pkg::all_parts_t   s1_parts_r;
  mswc_pkg::item_meta_t   s1_meta_r, s1_meta_nxt;
  mswc_pkg::all_parts_t   lane_parts;

  logic [3:0]             plen;
  logic [3:0]             pad_bytes;
  logic [5:0]             shamt;
  logic [63:0]            eff_mask;
  logic                   in_fire;
  logic [63:0]            hist_base;
  logic [21:0]            cnt_base;
  logic                   stuck;
  logic [71:0]            hist72;
  logic                   has_res;
  logic [21:0]            n_minus_p;
  logic                   merge_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r       <= 64'd0;
      pattern_mask_r  <= 64'd0;
      pattern_bytes_r <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        mswc_pkg::CFG_PATTERN: pattern_r       <= cfg_data;
        mswc_pkg::CFG_MASK:    pattern_mask_r  <= cfg_data;
        mswc_pkg::CFG_BYTES:   pattern_bytes_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_bytes_r == 4'd0) begin
      plen = 4'd1;
    end else if (pattern_bytes_r > 4'(mswc_pkg::MAX_PATTERN_BYTES)) begin
      plen = 4'(mswc_pkg::MAX_PATTERN_BYTES);
    end else begin
      plen = pattern_bytes_r;
    end
  end

  assign pad_bytes = 4'd8 - plen;
  assign shamt     = {pad_bytes[2:0], 3'b000};
  assign eff_mask  = pattern_mask_r & (~64'd0 << shamt);

  assign in_ready = !s1_valid_r || merge_ready;
  assign in_fire  = in_valid && in_ready;

  assign hist_base = in_item.frame_start ? 64'd0 : hist_r;
  assign cnt_base  = in_item.frame_start ? 22'd0 : cnt_r;
  assign stuck     = (cnt_base >= mswc_pkg::COUNT_MAX);
  assign hist72    = {hist_base, in_item.data_byte};
  assign n_minus_p = cnt_nxt - {18'd0, plen};
  assign has_res   = (cnt_nxt >= {18'd0, plen});

  always_comb begin
    hist_nxt           = hist_r;
    cnt_nxt            = stuck ? cnt_base : cnt_base + 22'd1;
    s1_meta_nxt.base   = {n_minus_p, 3'b000};
    s1_meta_nxt.stuck  = stuck;
    s1_meta_nxt.single = (cnt_nxt == {18'd0, plen});
    s1_valid_nxt       = s1_valid_r;
    if (in_fire) begin
      hist_nxt     = hist72[63:0];
      s1_valid_nxt = has_res;
    end else if (merge_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r     <= 64'd0;
      cnt_r      <= 22'd0;
      s1_valid_r <= 1'b0;
    end else begin
      hist_r     <= hist_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_parts_r <= lane_parts;
      s1_meta_r  <= s1_meta_nxt;
    end
  end

  for (genvar g = 0; g < mswc_pkg::NUM_LANES; g++) begin : g_lane
    mswc_lane u_lane (
      .hist72   (hist72),
      .lane_idx (3'(g)),
      .shamt    (shamt),
      .pattern  (pattern_r),
      .eff_mask (eff_mask),
      .parts    (lane_parts[g])
    );
  end

  mswc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_ready  (merge_ready),
    .s1_parts  (s1_parts_r),
    .s1_meta   (s1_meta_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `MSWC_ASSERT_NOW(a_count_range, clk, rst_n, out_valid, out_item.error_count <= 7'd64)
  `MSWC_ASSERT_NEXT(a_restart_clears, clk, rst_n, in_fire && in_item.frame_start,
    cnt_r == 22'd1 && hist_r[63:8] == 56'd0)
  `MSWC_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_r && !merge_ready, s1_valid_r)

endmodule

// File: verif/masked_sync_word_correlator_checker.sv
// scoreboard for the masked sync word correlator: predicts offset results and compares them
`timescale 1ns / 1ps
module masked_sync_word_correlator_checker
  import mswc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data,
  output int        mismatch_count,
  output int        pending_results
);

  logic [63:0] sync_pattern;
  logic [63:0] sync_mask;
  logic [3:0]  sync_len_bytes;
  logic [63:0] bit_history;
  logic [7:0]  spill_byte;
  logic [21:0] bytes_received;
  out_item_t   expected_corr [$];

  initial begin
    mismatch_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic correlate_byte(input in_item_t it);
    int unsigned plen;
    int unsigned wbits;
    int unsigned n;
    logic        stuck_now;
    logic [63:0] top_mask;
    logic [71:0] ext;
    logic [63:0] win;
    longint      off_wide;
    out_item_t   r;
    plen = sync_len_bytes;
    if (plen == 0) plen = 1;
    if (plen > MAX_PATTERN_BYTES) plen = MAX_PATTERN_BYTES;
    wbits = plen * 8;
    if (it.frame_start) begin
      bit_history = '0;
      spill_byte = '0;
      bytes_received = '0;
    end
    stuck_now = (bytes_received >= COUNT_MAX);
    spill_byte = bit_history[63:56];
    bit_history = {bit_history[55:0], it.data_byte};
    if (!stuck_now) bytes_received = bytes_received + 22'd1;
    n = bytes_received;
    if (n >= plen) begin
      top_mask = ~64'd0 << (64 - wbits);
      for (int j = 7; j >= 0; j--) begin
        if (n == plen && j != 0) continue;
        // window ends j bits above the newest bit
        ext = {spill_byte, bit_history} >> j;
        win = ext[63:0] << (64 - wbits);
        if (stuck_now) begin
          r.bit_offset = OFFSET_MAX;
        end else begin
          off_wide = (longint'(n) - longint'(plen)) * 8 - j;
          r.bit_offset = (off_wide > OFFSET_MAX) ? OFFSET_MAX : off_wide[23:0];
        end
        r.error_count = 7'($countones((win ^ sync_pattern) & sync_mask & top_mask));
        r.last_of_byte = (j == 0);
        expected_corr.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      sync_pattern = '0;
      sync_mask = '0;
      sync_len_bytes = 4'd1;
      bit_history = '0;
      spill_byte = '0;
      bytes_received = '0;
      expected_corr.delete();
      pending_results <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PATTERN: sync_pattern = cfg_data;
          CFG_MASK:    sync_mask = cfg_data;
          CFG_BYTES:   sync_len_bytes = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_corr.size() == 0) begin
          report_mismatch($sformatf("unexpected result offset %0d errors %0d",
                                    out_item.bit_offset, out_item.error_count));
        end else begin
          want = expected_corr.pop_front();
          if (out_item.bit_offset !== want.bit_offset)
            report_mismatch($sformatf("bit_offset got %0d want %0d",
                                      out_item.bit_offset, want.bit_offset));
          if (out_item.error_count !== want.error_count)
            report_mismatch($sformatf("error_count at offset %0d got %0d want %0d",
                                      want.bit_offset, out_item.error_count,
                                      want.error_count));
          if (out_item.last_of_byte !== want.last_of_byte)
            report_mismatch($sformatf("last_of_byte at offset %0d got %0b want %0b",
                                      want.bit_offset, out_item.last_of_byte,
                                      want.last_of_byte));
        end
      end
      if (in_valid && in_ready) correlate_byte(in_item);
      pending_results <= expected_corr.size();
    end
  end

endmodule

// File: verif/masked_sync_word_correlator_tb.sv
// testbench top for the masked sync word correlator: stimulus, flow control and verdict
`timescale 1ns / 1ps
module masked_sync_word_correlator_tb;
  import mswc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD = 400;
  localparam int ITEM_TARGET = 420;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit back_to_back = 1'b0;
  bit hold_req = 1'b0;

  always #10 clk = ~clk;

  masked_sync_word_correlator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  masked_sync_word_correlator_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("masked_sync_word_correlator_tb failed");
      $finish;
    end
  end

  // receiver: segments of steady, random and periodic ready, plus one long hold-off
  initial begin
    int seg_len;
    int mode;
    int period;
    out_ready <= 1'b0;
    forever begin
      seg_len = $urandom_range(10, 120);
      mode = $urandom_range(0, 2);
      period = $urandom_range(2, 5);
      for (int k = 0; k < seg_len; k++) begin
        @(posedge clk);
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (k % period == 0);
        endcase
      end
    end
  end

  task automatic write_config(input logic [63:0] pat, input logic [63:0] msk,
                              input logic [3:0] nbytes);
    cfg_idx_t    idx [3];
    logic [63:0] val [3];
    idx = '{CFG_PATTERN, CFG_MASK, CFG_BYTES};
    val = '{pat, msk, {$urandom, 28'($urandom), nbytes}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    in_valid <= 1'b1;
    in_item <= '{data_byte: b, frame_start: fs};
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!back_to_back) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 12);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // random lead-in, the sync word with sparse bit flips, random tail
  task automatic send_frame(input logic [63:0] pat, input int unsigned wbits,
                            input logic restart);
    logic       bq [$];
    int         lead;
    int         tail;
    int         flip_odds;
    logic [7:0] b;
    logic       fs;
    lead = $urandom_range(0, 20);
    tail = $urandom_range(0, 24);
    flip_odds = $urandom_range(0, 3);
    repeat (lead) bq.push_back(1'($urandom_range(0, 1)));
    for (int i = 0; i < wbits; i++)
      bq.push_back(pat[63-i] ^ (flip_odds != 0 && $urandom_range(0, 31) < flip_odds));
    repeat (tail) bq.push_back(1'($urandom_range(0, 1)));
    while (bq.size() % 8 != 0) bq.push_back(1'($urandom_range(0, 1)));
    fs = restart;
    b = '0;
    while (bq.size() > 0) begin
      for (int k = 0; k < 8; k++) b = {b[6:0], bq.pop_front()};
      send_byte(b, fs);
      fs = 1'b0;
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom), ($urandom_range(0, 9) == 0));
  endtask

  initial begin
    logic [63:0] pat;
    logic [63:0] msk;
    logic [3:0]  pb;
    int unsigned eff;
    int          phase;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PATTERN;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte pattern, all bits counted
    write_config('1, '1, 4'd1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_idle();

    // full 64-bit window: worst case then descending errors
    write_config('1, '1, 4'd8);
    send_byte(8'h00, 1'b1);
    repeat (7) send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();

    // zero length behaves as one, changed without a frame start
    write_config({4{16'hA5A5}}, {8{8'hF0}}, 4'd0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();

    // oversized length behaves as eight
    write_config('0, {$urandom, $urandom}, 4'd15);
    repeat (7) send_byte(8'($urandom), 1'b0);
    wait_idle();

    // empty mask
    write_config({$urandom, $urandom}, '0, 4'd3);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_idle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0)
        pb = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
      else
        pb = 4'($urandom_range(1, 8));
      if (phase == 0) pb = 4'd8;
      if (phase == 2) pb = 4'd1;
      eff = (pb == 0) ? 1 : (pb > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : pb;
      case ($urandom_range(0, 5))
        0: pat = '0;
        1: pat = '1;
        default: pat = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
        0, 1: msk = '1;
        2: msk = '0;
        default: msk = {$urandom, $urandom};
      endcase
      if (phase == 0) msk = '1;
      write_config(pat, msk, pb);

      if (phase == 1) begin
        hold_req = 1'b1;
        back_to_back = 1'b1;
        send_frame(pat, eff * 8, 1'b1);
        send_noise(40);
        back_to_back = 1'b0;
      end

      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) != 0)
          send_frame(pat, eff * 8, ($urandom_range(0, 9) != 0));
        else
          send_noise($urandom_range(4, 30));
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0)
      $display("masked_sync_word_correlator_tb passed");
    else
      $display("masked_sync_word_correlator_tb failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/mswc_pkg.sv
rtl/core/mswc_lane.sv
rtl/core/mswc_merge.sv
rtl/core/masked_sync_word_correlator.sv
verif/masked_sync_word_correlator_checker.sv
verif/masked_sync_word_correlator_tb.sv
